@@ sv/mcbp_pkg.sv @@
// Shared types, constants and helper functions of the multi-channel byte pipe.
package mcbp_pkg;

    localparam int NUM_PIPES  = 4;
    localparam int PIPE_DEPTH = 64;

    localparam int PID_W  = 2;
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;
    localparam int PTR_W  = $clog2(PIPE_DEPTH);
    localparam int ADDR_W = $clog2(NUM_PIPES * PIPE_DEPTH);

    localparam logic [PID_W:0]   NUM_PIPES_L  = (PID_W + 1)'(NUM_PIPES);
    localparam logic [CNT_W-1:0] PIPE_DEPTH_L = CNT_W'(PIPE_DEPTH);
    localparam logic [CNT_W-1:0] CAP_RESET    = CNT_W'(64);

    // Request types.
    localparam logic [1:0] REQ_WRITE     = 2'd0;
    localparam logic [1:0] REQ_READ      = 2'd1;
    localparam logic [1:0] REQ_CLEAR     = 2'd2;
    localparam logic [1:0] REQ_CLEAR_ALL = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [PID_W-1:0]  pipe_id;
        logic [BYTE_W-1:0] data_in;
        logic [CNT_W-1:0]  request_length;
        logic              run_start;
        logic              run_end;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] data_out;
        logic              byte_valid;
        logic [CNT_W-1:0]  byte_count;
        logic [CNT_W-1:0]  pending;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

    // Capacity register value clamped to the legal range.
    function automatic logic [CNT_W-1:0] cap_in_use(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > PIPE_DEPTH_L) begin
            r = PIPE_DEPTH_L;
        end
        return r;
    endfunction

    // Pointer step with wrap at the capacity in use.
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= cap) ? '0 : PTR_W'(n);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [PID_W-1:0] pid,
                                                    input logic [PTR_W-1:0] ptr);
        return ADDR_W'(ADDR_W'(pid) * ADDR_W'(PIPE_DEPTH)) + ADDR_W'(ptr);
    endfunction

endpackage

@@ sv/mcbp_store.sv @@
// Shared byte store of all pipes: one port, registered read data.
module mcbp_store (
    input  logic               aclk,
    input  mcbp_pkg::mem_req_t req,
    output logic [7:0]         rdata
);
    import mcbp_pkg::*;

    localparam int DEPTH = NUM_PIPES * PIPE_DEPTH;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mcbp_engine.sv @@
// Sequencer holding per-pipe pointers and occupancy, driving the byte store.
module mcbp_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [6:0]          cap_raw,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcbp_pkg::item_t     in_item,
    input  logic                out_free,
    output logic                emit,
    output mcbp_pkg::result_t   result,
    output mcbp_pkg::mem_req_t  mem_req,
    input  logic [7:0]          mem_rdata
);
    import mcbp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_EXEC    = 3'b010,
        S_RD_DATA = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    item_t            item_reg;
    logic [PTR_W-1:0] rd_ptr_reg [NUM_PIPES];
    logic [PTR_W-1:0] rd_ptr_next [NUM_PIPES];
    logic [PTR_W-1:0] wr_ptr_reg [NUM_PIPES];
    logic [PTR_W-1:0] wr_ptr_next [NUM_PIPES];
    logic [CNT_W-1:0] occ_reg [NUM_PIPES];
    logic [CNT_W-1:0] occ_next [NUM_PIPES];
    logic             run_acc_reg, run_acc_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       st_reg, st_next;

    logic [CNT_W-1:0] cap;
    logic [PID_W-1:0] pid;
    logic             pid_ok;
    logic [CNT_W-1:0] occ;
    logic [CNT_W-1:0] freesp;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] n_calc;
    logic [CNT_W-1:0] occ_left;
    logic             ra;
    logic             fin;

    assign cap      = cap_in_use(cap_raw);
    assign pid      = item_reg.pipe_id;
    assign pid_ok   = ({1'b0, pid} < NUM_PIPES_L);
    assign occ      = occ_reg[pid];
    assign freesp   = (cap > occ) ? (cap - occ) : '0;
    assign need     = (item_reg.request_length == '0) ? CNT_W'(1) : item_reg.request_length;
    assign n_calc   = (occ < item_reg.request_length) ? occ : item_reg.request_length;
    assign occ_left = occ - n_calc;
    assign ra       = item_reg.run_start ? (freesp >= need) : run_acc_reg;
    assign fin      = (cnt_reg == n_reg);
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        occ_next     = occ_reg;
        run_acc_next = run_acc_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        st_next      = st_reg;
        emit         = 1'b0;
        result       = '0;
        result.last  = 1'b1;
        mem_req      = '0;
        mem_req.wdata = item_reg.data_in;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (item_reg.req_type == REQ_CLEAR_ALL) begin
                        emit = 1'b1;
                        for (int i = 0; i < NUM_PIPES; i++) begin
                            rd_ptr_next[i] = '0;
                            wr_ptr_next[i] = '0;
                            occ_next[i]    = '0;
                        end
                    end else if (!pid_ok) begin
                        emit = 1'b1;
                    end else if (item_reg.req_type == REQ_CLEAR) begin
                        emit = 1'b1;
                        rd_ptr_next[pid] = '0;
                        wr_ptr_next[pid] = '0;
                        occ_next[pid]    = '0;
                    end else if (item_reg.req_type == REQ_WRITE) begin
                        emit           = 1'b1;
                        result.status  = ST_FULL;
                        result.pending = occ;
                        if (ra && (freesp != '0)) begin
                            mem_req.we       = 1'b1;
                            mem_req.addr     = store_addr(pid, wr_ptr_reg[pid]);
                            wr_ptr_next[pid] = next_ptr(wr_ptr_reg[pid], cap);
                            occ_next[pid]    = occ + CNT_W'(1);
                            result.status    = ST_OK;
                            result.pending   = occ + CNT_W'(1);
                        end
                        run_acc_next = item_reg.run_end ? 1'b0 : ra;
                    end else begin
                        // Read request.
                        if (occ == '0) begin
                            emit          = 1'b1;
                            result.status = ST_EMPTY;
                        end else if (n_calc == '0) begin
                            emit           = 1'b1;
                            result.status  = ST_NOT_EMPTY;
                            result.pending = occ;
                        end else begin
                            occ_next[pid]    = occ_left;
                            st_next          = (occ_left == '0) ? ST_OK : ST_NOT_EMPTY;
                            n_next           = n_calc;
                            cnt_next         = CNT_W'(1);
                            mem_req.re       = 1'b1;
                            mem_req.addr     = store_addr(pid, rd_ptr_reg[pid]);
                            rd_ptr_next[pid] = next_ptr(rd_ptr_reg[pid], cap);
                            state_next       = S_RD_DATA;
                        end
                    end
                end
            end
            S_RD_DATA: begin
                if (out_free) begin
                    emit              = 1'b1;
                    result.status     = st_reg;
                    result.data_out   = mem_rdata;
                    result.byte_valid = 1'b1;
                    result.byte_count = fin ? n_reg : '0;
                    result.pending    = occ;
                    result.last       = fin;
                    if (fin) begin
                        state_next = S_IDLE;
                    end else begin
                        mem_req.re       = 1'b1;
                        mem_req.addr     = store_addr(pid, rd_ptr_reg[pid]);
                        rd_ptr_next[pid] = next_ptr(rd_ptr_reg[pid], cap);
                        cnt_next         = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            run_acc_reg <= 1'b0;
            for (int i = 0; i < NUM_PIPES; i++) begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                occ_reg[i]    <= '0;
            end
        end else begin
            state_reg   <= state_next;
            run_acc_reg <= run_acc_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            occ_reg     <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
        n_reg   <= n_next;
        cnt_reg <= cnt_next;
        st_reg  <= st_next;
    end

endmodule

@@ sv/multi_channel_byte_pipe_unit.sv @@
// Top level of the multi-channel byte pipe: ports, capacity register, result register.
//
// Four circular byte pipes share one 256-byte store. Requests arrive on the s_
// channel (valid/ready): write one byte, read a burst, clear one pipe or clear
// all pipes. Results leave on the m_ channel (valid/ready), one per write or
// clear request and one per byte returned by a read (at least one per read).
// The capacity register is written through cfg_valid/cfg_ready/cfg_pipe_capacity,
// which is always ready; it is only to be written while the block is idle.
//
// Timing: a request is taken in the idle state and executed in the execute
// state once the output register is free. A write, clear or empty-read result
// is loaded into the output register when the request executes; the first byte
// of a read passes through the registered store read data before the output
// register. A read returns one byte per cycle after the first while the receiver
// does not stall. The store is never accessed twice in one cycle.
//
// Reset (aresetn low, synchronous) empties every pipe, clears the run flag,
// sets the capacity to 64 and drops any result held. The store is not
// cleared. When the receiver stalls, the result is held in the output
// register, and the sequencer waits without losing or repeating a result; a
// new request is still taken while a result waits.
module multi_channel_byte_pipe_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // Request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [1:0] s_pipe_id,
    input  logic [7:0] s_data_in,
    input  logic [6:0] s_request_length,
    input  logic       s_run_start,
    input  logic       s_run_end,
    // Result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_data_out,
    output logic       m_byte_valid,
    output logic [6:0] m_byte_count,
    output logic [6:0] m_pending,
    output logic       m_last,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_pipe_capacity
);
    import mcbp_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    item_t            in_item;
    result_t          eng_result;
    result_t          out_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             emit;
    mem_req_t         mem_req;
    logic [BYTE_W-1:0] mem_rdata;

    // The capacity register takes a write every cycle it is offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_pipe_capacity;
        end
    end

    assign in_item.req_type       = s_req_type;
    assign in_item.pipe_id        = s_pipe_id;
    assign in_item.data_in        = s_data_in;
    assign in_item.request_length = s_request_length;
    assign in_item.run_start      = s_run_start;
    assign in_item.run_end        = s_run_end;

    // The output register is free when empty or when its result leaves now.
    assign out_free = !out_valid_reg || m_ready;

    mcbp_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap_raw   (cap_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .out_free  (out_free),
        .emit      (emit),
        .result    (eng_result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    mcbp_store u_store (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // The engine only emits when the output register is free, so a result
    // is never overwritten.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= eng_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_reg.status;
    assign m_data_out   = out_reg.data_out;
    assign m_byte_valid = out_reg.byte_valid;
    assign m_byte_count = out_reg.byte_count;
    assign m_pending    = out_reg.pending;
    assign m_last       = out_reg.last;

endmodule
